@@ sv/lrp_pkg.sv @@
// Shared types, constants and the control program for the LFSR random permutation block.
// Used by lrp_sequencer, lrp_datapath and lfsr_random_permutation; depends on nothing.
package lrp_pkg;

   localparam int MAX_COUNT = 16;
   localparam int CNT_W     = $clog2(MAX_COUNT + 1);
   localparam int VAL_W     = $clog2(MAX_COUNT);
   localparam int LFSR_W    = 16;
   localparam int BIT_W     = $clog2(LFSR_W);
   localparam int UPC_W     = 3;

   localparam int TAP_A = 15;
   localparam int TAP_B = 14;
   localparam int TAP_C = 12;
   localparam int TAP_D = 3;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_STEP,
      OP_DIV,
      OP_PROBE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_ZERO_N,
      COND_DIV_BUSY,
      COND_USED,
      COND_NO_RSP,
      COND_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  target;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_ready;
      logic zero_n;
      logic div_busy;
      logic used;
      logic more;
   } status_type;

   localparam upc_type UA_WAIT   = 3'd0;
   localparam upc_type UA_TEST   = 3'd1;
   localparam upc_type UA_STEP   = 3'd2;
   localparam upc_type UA_DIV    = 3'd3;
   localparam upc_type UA_PROBE  = 3'd4;
   localparam upc_type UA_EMIT   = 3'd5;
   localparam upc_type UA_NEXT   = 3'd6;
   localparam upc_type UA_HOME   = 3'd7;

   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      w = '{op: OP_NONE, cond: COND_NEVER, target: UA_WAIT};
      unique case (addr)
         UA_WAIT:  w = '{op: OP_ACCEPT, cond: COND_NO_REQ,   target: UA_WAIT};
         UA_TEST:  w = '{op: OP_NONE,   cond: COND_ZERO_N,   target: UA_WAIT};
         UA_STEP:  w = '{op: OP_STEP,   cond: COND_NEVER,    target: UA_WAIT};
         UA_DIV:   w = '{op: OP_DIV,    cond: COND_DIV_BUSY, target: UA_DIV};
         UA_PROBE: w = '{op: OP_PROBE,  cond: COND_USED,     target: UA_PROBE};
         UA_EMIT:  w = '{op: OP_EMIT,   cond: COND_NO_RSP,   target: UA_EMIT};
         UA_NEXT:  w = '{op: OP_NONE,   cond: COND_MORE,     target: UA_STEP};
         UA_HOME:  w = '{op: OP_NONE,   cond: COND_ALWAYS,   target: UA_WAIT};
      endcase
      return w;
   endfunction

endpackage

@@ sv/lrp_sequencer.sv @@
// Step counter, control store and jump logic of the permutation block.
// Depends on lrp_pkg for the control word layout and the program.
module lrp_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  lrp_pkg::status_type status,
   output lrp_pkg::uword_type  uword
);
   import lrp_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;
   logic    taken;

   assign uword = ucode_rom(upc_ff);

   always_comb begin
      unique case (uword.cond)
         COND_NEVER:    taken = 1'b0;
         COND_ALWAYS:   taken = 1'b1;
         COND_NO_REQ:   taken = ~status.req_valid;
         COND_ZERO_N:   taken = status.zero_n;
         COND_DIV_BUSY: taken = status.div_busy;
         COND_USED:     taken = status.used;
         COND_NO_RSP:   taken = ~status.rsp_ready;
         COND_MORE:     taken = status.more;
      endcase
   end

   assign upc_in = taken ? uword.target : upc_ff + upc_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

@@ sv/lrp_datapath.sv @@
// LFSR, bit-serial remainder unit, probe pointer and used flags of the permutation block.
// Depends on lrp_pkg; driven by the control word from lrp_sequencer.
module lrp_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  lrp_pkg::uword_type        uword,
   output lrp_pkg::status_type       status,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lrp_pkg::CNT_W-1:0] req_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lrp_pkg::VAL_W-1:0] rsp_perm_value,
   output logic                      rsp_last
);
   import lrp_pkg::*;

   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [MAX_COUNT-1:0] used_ff, used_in;

   logic [CNT_W-1:0]     count_sat;
   logic [VAL_W:0]       part;
   logic [VAL_W:0]       part_red;
   logic [CNT_W-1:0]     pos_inc;
   logic                 feedback;

   assign req_ready = (uword.op == OP_ACCEPT);
   assign rsp_valid = (uword.op == OP_EMIT);

   assign count_sat = (req_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : req_count;
   assign feedback  = ~(lfsr_ff[TAP_A] ^ lfsr_ff[TAP_B] ^ lfsr_ff[TAP_C] ^ lfsr_ff[TAP_D]);
   assign part      = {rem_ff, lfsr_ff[BIT_W'(LFSR_W-1) - bit_ff]};
   assign part_red  = ((VAL_W+1)'(part) >= (VAL_W+1)'(n_ff)) ?
                      part - (VAL_W+1)'(n_ff) : part;
   assign pos_inc   = CNT_W'(rem_ff) + CNT_W'(1);

   always_comb begin
      lfsr_in = lfsr_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      used_in = used_ff;
      case (uword.op)
         OP_ACCEPT: begin
            if (req_valid) begin
               n_in    = count_sat;
               k_in    = '0;
               used_in = '0;
            end
         end
         OP_STEP: begin
            lfsr_in = {lfsr_ff[LFSR_W-2:0], feedback};
            rem_in  = '0;
            bit_in  = '0;
         end
         OP_DIV: begin
            rem_in = part_red[VAL_W-1:0];
            bit_in = bit_ff + BIT_W'(1);
         end
         OP_PROBE: begin
            if (used_ff[rem_ff]) begin
               rem_in = (pos_inc == n_ff) ? '0 : pos_inc[VAL_W-1:0];
            end
         end
         OP_EMIT: begin
            if (rsp_ready) begin
               used_in[rem_ff] = 1'b1;
               k_in            = k_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= '0;
         n_ff    <= '0;
         k_ff    <= '0;
         used_ff <= '0;
      end else begin
         lfsr_ff <= lfsr_in;
         n_ff    <= n_in;
         k_ff    <= k_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bit_ff <= bit_in;
   end

   assign status.req_valid = req_valid;
   assign status.rsp_ready = rsp_ready;
   assign status.zero_n    = (n_ff == '0);
   assign status.div_busy  = (bit_ff != BIT_W'(LFSR_W-1));
   assign status.used      = used_ff[rem_ff];
   assign status.more      = (k_ff != n_ff);

   assign rsp_perm_value = rem_ff;
   assign rsp_last       = ((k_ff + CNT_W'(1)) == n_ff);

endmodule

@@ sv/lfsr_random_permutation.sv @@
// Top level of the LFSR random permutation generator.
// Depends on lrp_pkg, lrp_sequencer and lrp_datapath.
//
// Usage: a request transfer on req_valid/req_ready carries req_count (0..16;
// larger counts saturate to 16). With count the saturated req_count, the block
// answers with count result transfers on rsp_valid/rsp_ready, each carrying
// one value of a random permutation of 0..count-1 in rsp_perm_value; rsp_last
// marks the final one. A count of 0 yields no results. One request is handled
// at a time: req_ready is high only while the block waits for a request.
// Flow: a request is accepted and its count tested, then for each value the
// block steps the LFSR, forms the bit-serial remainder of the LFSR by the count,
// walks the probe over occupied slots (up to count-1) to a free one and emits
// it; after the last value it returns to waiting. The bit-serial remainder
// takes most of the time per value.
// A stalled receiver holds the current value on the result port and freezes
// the program until the transfer completes. Reset clears the LFSR to zero,
// the used flags and the step counter, and leaves the block waiting for a
// request. The LFSR carries over from request to request.
module lfsr_random_permutation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lrp_pkg::CNT_W-1:0] req_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [lrp_pkg::VAL_W-1:0] rsp_perm_value,
   output logic                      rsp_last
);
   import lrp_pkg::*;

   uword_type  uword;
   status_type status;

   lrp_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   lrp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .uword          (uword),
      .status         (status),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_perm_value (rsp_perm_value),
      .rsp_last       (rsp_last)
   );

endmodule
